### rtl/tea_pkg.sv
// tea_pkg: shared constants, types and helpers for the tea block decrypt pipeline
package tea_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned ROUNDS    = 32;
    localparam int unsigned STAGES    = 2 * ROUNDS;
    localparam int unsigned KEY_WORDS = 4;
    localparam int unsigned KEY_IDX_W = $clog2(KEY_WORDS);

    localparam logic [WORD_W-1:0] DELTA = 32'h9e37_79b9;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [KEY_IDX_W-1:0] {
        REG_KEY0 = 2'd0,
        REG_KEY1 = 2'd1,
        REG_KEY2 = 2'd2,
        REG_KEY3 = 2'd3
    } key_index_t;

    typedef struct packed {
        logic  valid;
        word_t w0;
        word_t w1;
    } stage_t;

    // running sum seen by round r: delta * (rounds - r), wrapped to a word
    function automatic word_t round_sum(input int unsigned r);
        logic [2*WORD_W-1:0] prod;
        prod = (2*WORD_W)'(DELTA) * (2*WORD_W)'(ROUNDS - r);
        return prod[WORD_W-1:0];
    endfunction

    function automatic word_t tea_mix(input word_t w, input word_t sum,
                                      input word_t ka, input word_t kb);
        word_t a;
        word_t b;
        word_t c;
        a = (w << 4) + ka;
        b = w + sum;
        c = (w >> 5) + kb;
        return a ^ b ^ c;
    endfunction

endpackage

### rtl/tea_block_decrypt.sv
// tea_block_decrypt: 32-round tea block decryption, one half round per pipeline stage
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall    cipher_low, cipher_high
//   out       output     out_valid / out_stall  plain_low, plain_high
//   cfg       input      cfg_wr_en              cfg_index, cfg_wdata
//
// one block enters per cycle while in_stall is low; data passes 2 * rounds half-round
// stages plus one output register; each stage: three adds, two xors and a subtract
// reset clears the key words and all valid bits; no clearing pass
// a two-entry output buffer holds results; the pipeline freezes only when both
// are full, and in_stall comes straight from a register
module tea_block_decrypt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [tea_pkg::WORD_W-1:0]      cipher_low,
    input  logic [tea_pkg::WORD_W-1:0]      cipher_high,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [tea_pkg::WORD_W-1:0]      plain_low,
    output logic [tea_pkg::WORD_W-1:0]      plain_high,
    input  logic                            cfg_wr_en,
    input  logic [tea_pkg::KEY_IDX_W-1:0]   cfg_index,
    input  logic [tea_pkg::WORD_W-1:0]      cfg_wdata
);

    tea_pkg::word_t  key_reg [tea_pkg::KEY_WORDS];
    tea_pkg::stage_t pipe [tea_pkg::STAGES+1];

    logic            advance;
    logic            take;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            skid_valid_reg;
    logic            skid_valid_next;
    tea_pkg::word_t  out_low_reg;
    tea_pkg::word_t  out_high_reg;
    tea_pkg::word_t  out_low_next;
    tea_pkg::word_t  out_high_next;
    tea_pkg::word_t  skid_low_reg;
    tea_pkg::word_t  skid_high_reg;
    tea_pkg::word_t  skid_low_next;
    tea_pkg::word_t  skid_high_next;
    tea_pkg::stage_t last;

    // key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tea_pkg::KEY_WORDS; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            case (tea_pkg::key_index_t'(cfg_index))
                tea_pkg::REG_KEY0: key_reg[0] <= cfg_wdata;
                tea_pkg::REG_KEY1: key_reg[1] <= cfg_wdata;
                tea_pkg::REG_KEY2: key_reg[2] <= cfg_wdata;
                tea_pkg::REG_KEY3: key_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign advance  = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    assign pipe[0].valid = in_valid;
    assign pipe[0].w0    = cipher_low;
    assign pipe[0].w1    = cipher_high;

    for (genvar k = 0; k < tea_pkg::STAGES; k++)
    begin : g_stage
        tea_half_round u_half (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .upd_high  ((k % 2) == 0),
            .sum       (tea_pkg::round_sum(k / 2)),
            .ka        (((k % 2) == 0) ? key_reg[2] : key_reg[0]),
            .kb        (((k % 2) == 0) ? key_reg[3] : key_reg[1]),
            .stage_in  (pipe[k]),
            .stage_out (pipe[k+1])
        );
    end

    assign last = pipe[tea_pkg::STAGES];
    assign take = out_valid_reg && !out_stall;

    // output register and skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_low_next    = out_low_reg;
        out_high_next   = out_high_reg;
        skid_low_next   = skid_low_reg;
        skid_high_next  = skid_high_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_low_next    = skid_low_reg;
                out_high_next   = skid_high_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (last.valid)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_next = 1'b1;
                out_low_next   = last.w0;
                out_high_next  = last.w1;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_low_next   = last.w0;
                skid_high_next  = last.w1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_low_reg   <= out_low_next;
        out_high_reg  <= out_high_next;
        skid_low_reg  <= skid_low_next;
        skid_high_reg <= skid_high_next;
    end

    assign out_valid  = out_valid_reg;
    assign plain_low  = out_low_reg;
    assign plain_high = out_high_reg;

    // skid entry is only used behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output register empty");

    // skid fills only when a result arrives at a stalled output
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall && last.valid))
        else $error("skid entry filled without a stalled output");

    // a held skid transaction with a stalled output keeps the input stalled
    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_stall) |=> (skid_valid_reg && in_stall))
        else $error("skid entry dropped while output stalled");

endmodule

### rtl/tea_half_round.sv
// tea_half_round: one registered half round of tea decryption
module tea_half_round (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             upd_high,
    input  tea_pkg::word_t   sum,
    input  tea_pkg::word_t   ka,
    input  tea_pkg::word_t   kb,
    input  tea_pkg::stage_t  stage_in,
    output tea_pkg::stage_t  stage_out
);

    logic           valid_reg;
    tea_pkg::word_t w0_reg;
    tea_pkg::word_t w1_reg;
    tea_pkg::word_t w0_next;
    tea_pkg::word_t w1_next;

    always_comb
    begin
        w0_next = stage_in.w0;
        w1_next = stage_in.w1;
        if (upd_high)
        begin
            w1_next = stage_in.w1 - tea_pkg::tea_mix(stage_in.w0, sum, ka, kb);
        end
        else
        begin
            w0_next = stage_in.w0 - tea_pkg::tea_mix(stage_in.w1, sum, ka, kb);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage_in.valid)
        begin
            w0_reg <= w0_next;
            w1_reg <= w1_next;
        end
    end

    assign stage_out.valid = valid_reg;
    assign stage_out.w0    = w0_reg;
    assign stage_out.w1    = w1_reg;

endmodule
